### sv/grdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grdc_pkg
// shared types and constants of the grid ray caster
// ----------------------------------------------------------------------------
package grdc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VEC_BITS  = 14;
    localparam int POS_W     = 22;
    localparam int VEC_W     = 16;
    localparam int SCR_W     = 13;
    localparam int TEXW_W    = 11;
    localparam int COL_W     = 12;
    localparam int COORD_W   = 6;
    localparam int CELL_W    = 2;
    localparam int DIST_W    = 24;
    localparam int TEXC_W    = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [TEXW_W-1:0] TEXW_MAX = TEXW_W'(1024);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_POS_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 3'd7;

    // item kinds
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CAST  = 1'b1;

    // cell codes
    localparam logic [CELL_W-1:0] CELL_EMPTY = 2'd0;
    localparam logic [CELL_W-1:0] CELL_WALL  = 2'd1;
    localparam logic [CELL_W-1:0] CELL_SKIP  = 2'd2;
    localparam logic [CELL_W-1:0] CELL_KEEP  = 2'd3;

    // wall faces
    localparam logic [1:0] FACE_WEST  = 2'd0;
    localparam logic [1:0] FACE_EAST  = 2'd1;
    localparam logic [1:0] FACE_NORTH = 2'd2;
    localparam logic [1:0] FACE_SOUTH = 2'd3;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CAM_DIV,
        S_RAYX_MUL,
        S_RAYY_MUL,
        S_RAYY_SET,
        S_DX_DIV,
        S_DY_DIV,
        S_SX_MUL,
        S_SY_MUL,
        S_SY_SET,
        S_STEP,
        S_READ,
        S_TEST,
        S_NUM,
        S_OFF_MUL,
        S_DIST_DIV,
        S_OFF_DIV,
        S_TEX_MUL,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

### sv/grid_ray_dda_caster.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_ray_dda_caster
// column raycaster: dda walk over a 2-bit cell grid, one shared divider and
// one shared multiplier under a sequencer
// ----------------------------------------------------------------------------
// After reset the block clears all GRID_DIM*GRID_DIM cells of the grid store
// (4096 at the default size), one cell per cycle; it takes no transaction
// meanwhile, configuration writes are taken as ever. A write transaction
// (tuser 0) stores one cell and gives no result. A cast transaction
// (tuser 1) runs setup and finish work with five passes through the shared
// radix-2 divider (the camera coordinate, two step deltas, the distance and
// the hit offset) around a walk over the grid cells, in which the skip mark
// doubles the step; the walk is capped at 4*GRID_DIM+8 cells. The grid
// memory has one registered read port. A finished result sits in the output
// register, so a new transaction can be taken while it waits for the sink.
// ----------------------------------------------------------------------------
module grid_ray_dda_caster #(
    parameter int GRID_DIM = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // cfg write port
    input  wire                              i_cfg_we,
    input  wire [grdc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [grdc_pkg::POS_W-1:0]        i_cfg_data,
    // input stream
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // [11:0] column, [17:12] cell_x, [23:18] cell_y, [25:24] cell_value
    input  wire [31:0]                       i_s_tdata,
    // [0] func
    input  wire                              i_s_tuser,
    // result stream
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // [23:0] distance, [24] hit_side, [26:25] face, [36:27] tex_column,
    // [42:37] hit_x, [48:43] hit_y
    output logic [55:0]                      o_m_tdata,
    // [0] escaped
    output logic                             o_m_tuser
);
    import grdc_pkg::*;

    localparam int DEPTH = GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = (($clog2(GRID_DIM) > COORD_W) ? $clog2(GRID_DIM) : COORD_W) + 2;
    localparam int LIMIT = 4 * GRID_DIM + 8;
    localparam int NCW   = $clog2(LIMIT);
    localparam int CAMW  = 29;
    localparam int RW    = 32;
    localparam int DW    = 31;
    localparam int SW    = 34 + $clog2(LIMIT);
    localparam int NW    = MW + FRAC_BITS + 2;
    localparam int MULW  = 33;
    localparam int PW    = 2 * MULW;
    localparam int DVW   = 64;
    localparam int DVDW  = 32;
    localparam int DVCW  = 7;

    // configuration registers
    logic [POS_W-1:0]         r_pos_x, r_pos_y;
    logic signed [VEC_W-1:0]  r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [SCR_W-1:0]         r_scr_w;
    logic [TEXW_W-1:0]        r_tex_w;

    t_state r_state, n_state;

    // grid store
    logic [CELL_W-1:0]        r_grid [DEPTH];
    logic [AW-1:0]            r_clr;
    logic [CELL_W-1:0]        r_cell;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [CELL_W-1:0]        mem_wdata;
    logic [AW-1:0]            mem_raddr;

    // shared divider
    logic [DVW-1:0]           r_dv_q;
    logic [DVDW-1:0]          r_dv_rem, r_dv_den;
    logic [DVCW-1:0]          r_dv_cnt;
    logic                     dv_start, dv_done;
    logic [DVW-1:0]           dv_dividend;
    logic [DVDW-1:0]          dv_divisor;
    logic [DVDW:0]            dv_shift;
    logic                     dv_ge;

    // shared multiplier
    logic                     mul_en;
    logic signed [MULW-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]     r_prod;

    // cast datapath
    logic signed [CAMW-1:0]   r_cam;
    logic signed [RW-1:0]     r_rayx, r_rayy;
    logic [DW-1:0]            r_dx, r_dy;
    logic [SW-1:0]            r_sx, r_sy;
    logic signed [MW-1:0]     r_mx, r_my;
    logic                     r_side, r_skip, r_second, r_hit;
    logic [NCW-1:0]           r_n;
    logic signed [NW-1:0]     r_num;
    logic signed [RW-1:0]     r_den, r_other;
    logic [FRAC_BITS-1:0]     r_base, r_off;
    logic [1:0]               r_face;
    logic [DIST_W-1:0]        r_dist;

    // output register
    logic                     r_m_valid;
    logic [55:0]              r_m_data;
    logic                     r_m_esc;

    // combinational helpers
    logic                     in_acc, out_free;
    logic [SCR_W-1:0]         scr_w_eff;
    logic [TEXW_W-1:0]        tex_w_eff;
    logic [DW-1:0]            delta_q;
    logic [FRAC_BITS:0]       fx, fy;
    logic                     step_x;
    logic signed [MW-1:0]     n_mx, n_my;
    logic                     step_out;
    logic [CELL_W-1:0]        n_skip_code;
    logic                     n_skip;
    logic signed [MW-1:0]     cross_m;
    logic signed [NW-1:0]     n_num;
    logic [NW-1:0]            num_mag;
    logic [RW-1:0]            den_mag, rayx_mag, rayy_mag;
    logic [PW-1:0]            prod_mag;
    logic                     off_neg, rem_nz;
    logic [FRAC_BITS-1:0]     n_off, fr;
    logic [COORD_W-1:0]       wr_x, wr_y;

    assign in_acc   = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_esc;

    assign wr_x = i_s_tdata[COL_W +: COORD_W];
    assign wr_y = i_s_tdata[COL_W+COORD_W +: COORD_W];

    // clamped config views
    assign scr_w_eff = (r_scr_w == '0) ? SCR_W'(1) : r_scr_w;
    always_comb begin
        if (r_tex_w == '0) begin
            tex_w_eff = TEXW_W'(1);
        end else if (r_tex_w > TEXW_MAX) begin
            tex_w_eff = TEXW_MAX;
        end else begin
            tex_w_eff = r_tex_w;
        end
    end

    assign rayx_mag = r_rayx[RW-1] ? RW'(-r_rayx) : RW'(r_rayx);
    assign rayy_mag = r_rayy[RW-1] ? RW'(-r_rayy) : RW'(r_rayy);

    // first side distances: fraction toward the first boundary
    assign fx = r_rayx[RW-1] ? {1'b0, r_pos_x[FRAC_BITS-1:0]}
                             : (FRAC_BITS+1)'(2**FRAC_BITS) - {1'b0, r_pos_x[FRAC_BITS-1:0]};
    assign fy = r_rayy[RW-1] ? {1'b0, r_pos_y[FRAC_BITS-1:0]}
                             : (FRAC_BITS+1)'(2**FRAC_BITS) - {1'b0, r_pos_y[FRAC_BITS-1:0]};

    // one dda step
    assign step_x = (r_sx < r_sy);
    always_comb begin
        n_mx = r_mx;
        n_my = r_my;
        if (step_x) begin
            n_mx = r_rayx[RW-1] ? r_mx - MW'(1) : r_mx + MW'(1);
        end else begin
            n_my = r_rayy[RW-1] ? r_my - MW'(1) : r_my + MW'(1);
        end
    end
    assign step_out = n_mx[MW-1] || n_my[MW-1]
                   || ($signed(n_mx) >= $signed(MW'(GRID_DIM)))
                   || ($signed(n_my) >= $signed(MW'(GRID_DIM)));

    // skip mark after entering a cell
    assign n_skip_code = r_cell;
    always_comb begin
        case (n_skip_code)
            CELL_SKIP:  n_skip = 1'b1;
            CELL_EMPTY: n_skip = 1'b0;
            default:    n_skip = r_skip;
        endcase
    end

    // distance numerator along the crossed axis
    assign cross_m = r_side ? r_my : r_mx;
    always_comb begin
        n_num = $signed({{2{cross_m[MW-1]}}, cross_m, {FRAC_BITS{1'b0}}})
              - $signed(NW'(r_side ? r_pos_y : r_pos_x));
        if (r_side ? r_rayy[RW-1] : r_rayx[RW-1]) begin
            n_num = n_num + $signed(NW'(2**FRAC_BITS));
        end
    end
    assign num_mag  = r_num[NW-1] ? NW'(-r_num) : NW'(r_num);
    assign den_mag  = r_den[RW-1] ? RW'(-r_den) : RW'(r_den);
    assign prod_mag = r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);

    // step delta quotient, special cases handled where it is stored
    assign delta_q = r_dv_q[DW-1:0];

    // floor of the hit offset, low fraction bits only
    assign off_neg = r_prod[PW-1] ^ r_den[RW-1];
    assign rem_nz  = (r_dv_rem != '0);
    assign n_off   = (r_den == '0) ? '0
                   : off_neg ? (FRAC_BITS'(0) - r_dv_q[FRAC_BITS-1:0] - FRAC_BITS'(rem_nz))
                   : r_dv_q[FRAC_BITS-1:0];
    assign fr = r_base + r_off;

    // divider step
    assign dv_done  = (r_dv_cnt == '0);
    assign dv_shift = {r_dv_rem, r_dv_q[DVW-1]};
    assign dv_ge    = (dv_shift >= {1'b0, r_dv_den});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:    if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:     if (in_acc && i_s_tuser == FUNC_CAST) n_state = S_CAM_DIV;
            S_CAM_DIV:  if (dv_done) n_state = S_RAYX_MUL;
            S_RAYX_MUL: n_state = S_RAYY_MUL;
            S_RAYY_MUL: n_state = S_RAYY_SET;
            S_RAYY_SET: n_state = S_DX_DIV;
            S_DX_DIV:   if (dv_done) n_state = S_DY_DIV;
            S_DY_DIV:   if (dv_done) n_state = S_SX_MUL;
            S_SX_MUL:   n_state = S_SY_MUL;
            S_SY_MUL:   n_state = S_SY_SET;
            S_SY_SET:   n_state = S_STEP;
            S_STEP: begin
                if (step_out) begin
                    n_state = S_DONE;
                end else if (!r_second) begin
                    n_state = S_READ;
                end
            end
            S_READ:     n_state = S_TEST;
            S_TEST: begin
                if (r_cell == CELL_WALL) begin
                    n_state = S_NUM;
                end else if (r_n == NCW'(LIMIT - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_NUM:      n_state = S_OFF_MUL;
            S_OFF_MUL:  n_state = S_DIST_DIV;
            S_DIST_DIV: if (dv_done) n_state = S_OFF_DIV;
            S_OFF_DIV:  if (dv_done) n_state = S_TEX_MUL;
            S_TEX_MUL:  n_state = S_DONE;
            S_DONE:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_CLEAR;
        endcase
    end

    // unit controls per state
    always_comb begin
        dv_start    = 1'b0;
        dv_dividend = '0;
        dv_divisor  = '0;
        mul_en      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        mem_we      = 1'b0;
        mem_waddr   = r_clr;
        mem_wdata   = CELL_EMPTY;
        mem_raddr   = AW'(r_mx) * AW'(GRID_DIM) + AW'(r_my);
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_IDLE: begin
                dv_start    = in_acc && (i_s_tuser == FUNC_CAST);
                dv_dividend = DVW'({i_s_tdata[COL_W-1:0], 1'b0}) << VEC_BITS;
                dv_divisor  = DVDW'(scr_w_eff);
                mem_we      = in_acc && (i_s_tuser == FUNC_WRITE)
                           && (int'(wr_x) < GRID_DIM) && (int'(wr_y) < GRID_DIM);
                mem_waddr   = AW'(wr_x) * AW'(GRID_DIM) + AW'(wr_y);
                mem_wdata   = i_s_tdata[COL_W+2*COORD_W +: CELL_W];
            end
            S_RAYX_MUL: begin
                mul_en = 1'b1;
                mul_a  = MULW'(r_plane_x);
                mul_b  = MULW'(r_cam);
            end
            S_RAYY_MUL: begin
                mul_en = 1'b1;
                mul_a  = MULW'(r_plane_y);
                mul_b  = MULW'(r_cam);
            end
            S_RAYY_SET: begin
                dv_start    = 1'b1;
                dv_dividend = DVW'(1) << (FRAC_BITS + VEC_BITS);
                dv_divisor  = rayx_mag;
            end
            S_DX_DIV: begin
                dv_start    = dv_done;
                dv_dividend = DVW'(1) << (FRAC_BITS + VEC_BITS);
                dv_divisor  = rayy_mag;
            end
            S_SX_MUL: begin
                mul_en = 1'b1;
                mul_a  = MULW'(fx);
                mul_b  = MULW'(r_dx);
            end
            S_SY_MUL: begin
                mul_en = 1'b1;
                mul_a  = MULW'(fy);
                mul_b  = MULW'(r_dy);
            end
            S_OFF_MUL: begin
                mul_en      = 1'b1;
                mul_a       = MULW'(r_num);
                mul_b       = MULW'(r_other);
                dv_start    = 1'b1;
                dv_dividend = DVW'(num_mag) << VEC_BITS;
                dv_divisor  = den_mag;
            end
            S_DIST_DIV: begin
                dv_start    = dv_done;
                dv_dividend = DVW'(prod_mag);
                dv_divisor  = den_mag;
            end
            S_TEX_MUL: begin
                mul_en = 1'b1;
                mul_a  = MULW'(fr);
                mul_b  = MULW'(tex_w_eff);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // state and clearing counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_dir_x   <= 16'sd16384;
            r_dir_y   <= '0;
            r_plane_x <= '0;
            r_plane_y <= 16'sd10813;
            r_scr_w   <= SCR_W'(640);
            r_tex_w   <= TEXW_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POS_X:     r_pos_x   <= i_cfg_data;
                CFG_POS_Y:     r_pos_y   <= i_cfg_data;
                CFG_DIR_X:     r_dir_x   <= i_cfg_data[VEC_W-1:0];
                CFG_DIR_Y:     r_dir_y   <= i_cfg_data[VEC_W-1:0];
                CFG_PLANE_X:   r_plane_x <= i_cfg_data[VEC_W-1:0];
                CFG_PLANE_Y:   r_plane_y <= i_cfg_data[VEC_W-1:0];
                CFG_SCR_WIDTH: r_scr_w   <= i_cfg_data[SCR_W-1:0];
                CFG_TEX_WIDTH: r_tex_w   <= i_cfg_data[TEXW_W-1:0];
                default:       r_pos_x   <= r_pos_x;
            endcase
        end
    end

    // grid memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_cell <= r_grid[mem_raddr];
        end
    end

    // shared restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_cnt <= '0;
        end else if (dv_start) begin
            r_dv_cnt <= DVCW'(DVW);
        end else if (!dv_done) begin
            r_dv_cnt <= r_dv_cnt - DVCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_start) begin
            r_dv_q   <= dv_dividend;
            r_dv_rem <= '0;
            r_dv_den <= dv_divisor;
        end else if (!dv_done) begin
            r_dv_q   <= {r_dv_q[DVW-2:0], dv_ge};
            r_dv_rem <= dv_ge ? DVDW'(dv_shift - {1'b0, r_dv_den}) : DVDW'(dv_shift);
        end
    end

    // shared multiplier with registered product
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // cast datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_CAM_DIV: begin
                if (dv_done) begin
                    r_cam <= $signed(r_dv_q[CAMW-1:0]) - CAMW'(2**VEC_BITS);
                end
            end
            S_RAYY_MUL: r_rayx <= RW'(r_dir_x) + RW'(r_prod >>> VEC_BITS);
            S_RAYY_SET: r_rayy <= RW'(r_dir_y) + RW'(r_prod >>> VEC_BITS);
            S_DX_DIV: begin
                if (dv_done) begin
                    if (r_rayy == '0) begin
                        r_dx <= '0;
                    end else if (r_rayx == '0) begin
                        r_dx <= DW'(2**FRAC_BITS);
                    end else begin
                        r_dx <= delta_q;
                    end
                end
            end
            S_DY_DIV: begin
                if (dv_done) begin
                    if (r_rayx == '0) begin
                        r_dy <= '0;
                    end else if (r_rayy == '0) begin
                        r_dy <= DW'(2**FRAC_BITS);
                    end else begin
                        r_dy <= delta_q;
                    end
                end
            end
            S_SY_MUL: r_sx <= SW'(r_prod[FRAC_BITS +: 32]);
            S_SY_SET: begin
                r_sy     <= SW'(r_prod[FRAC_BITS +: 32]);
                r_mx     <= MW'(r_pos_x[POS_W-1:FRAC_BITS]);
                r_my     <= MW'(r_pos_y[POS_W-1:FRAC_BITS]);
                r_n      <= '0;
                r_skip   <= 1'b0;
                r_second <= 1'b0;
                r_hit    <= 1'b0;
                r_side   <= 1'b0;
            end
            S_STEP: begin
                r_second <= 1'b0;
                r_side   <= !step_x;
                r_mx     <= n_mx;
                r_my     <= n_my;
                if (step_x) begin
                    r_sx <= r_sx + SW'(r_dx);
                end else begin
                    r_sy <= r_sy + SW'(r_dy);
                end
            end
            S_TEST: begin
                r_n      <= r_n + NCW'(1);
                r_skip   <= n_skip;
                r_second <= n_skip;
                r_hit    <= (r_cell == CELL_WALL);
            end
            S_NUM: begin
                r_num   <= n_num;
                r_den   <= r_side ? r_rayy : r_rayx;
                r_other <= r_side ? r_rayx : r_rayy;
                r_base  <= r_side ? r_pos_x[FRAC_BITS-1:0] : r_pos_y[FRAC_BITS-1:0];
                if (r_side) begin
                    r_face <= r_rayy[RW-1] ? FACE_NORTH : FACE_SOUTH;
                end else begin
                    r_face <= r_rayx[RW-1] ? FACE_WEST : FACE_EAST;
                end
            end
            S_DIST_DIV: begin
                if (dv_done) begin
                    if (r_den == '0) begin
                        r_dist <= DIST_MAX;
                    end else if ((r_num != '0) && (r_num[NW-1] != r_den[RW-1])) begin
                        r_dist <= '0;
                    end else if (r_dv_q[DVW-1:DIST_W] != '0) begin
                        r_dist <= DIST_MAX;
                    end else begin
                        r_dist <= r_dv_q[DIST_W-1:0];
                    end
                end
            end
            S_OFF_DIV: begin
                if (dv_done) begin
                    r_off <= n_off;
                end
            end
            default: begin
                r_second <= r_second;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            if (r_hit) begin
                r_m_data <= {7'd0,
                             r_my[COORD_W-1:0],
                             r_mx[COORD_W-1:0],
                             r_prod[FRAC_BITS +: TEXC_W],
                             r_face,
                             r_side,
                             r_dist};
                r_m_esc  <= 1'b0;
            end else begin
                r_m_data <= {32'd0, DIST_MAX};
                r_m_esc  <= 1'b1;
            end
        end
    end

    // an escaped result always carries the saturated distance
    a_esc_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_esc) |-> (r_m_data[DIST_W-1:0] == DIST_MAX))
        else $error("escaped result without saturated distance");

    // no transaction and no result while the grid is being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!o_s_tready && !r_m_valid))
        else $error("activity during clearing pass");

    // a cast starts the divider for the camera coordinate
    a_cast_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_tuser == FUNC_CAST) |=> (r_state == S_CAM_DIV && !dv_done))
        else $error("cast did not start the divider");

    // the walk never runs with the divider busy
    a_walk_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP || r_state == S_TEST) |-> dv_done)
        else $error("divider busy during walk");

    // cell count of the walk stays under its cap
    a_walk_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEST) |-> (int'(r_n) < LIMIT))
        else $error("walk exceeded cell cap");

endmodule
`default_nettype wire
